@@ rtl/lpfr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpfr_pkg: shared types and helpers of the length-prefixed frame ring
// Ring geometry, command and status codes, register indexes, the write
// request that travels to the banked byte store, and position arithmetic.
// ----------------------------------------------------------------------------
package lpfr_pkg;

   // Ring size in bytes. It must be a multiple of four, since the store is
   // split into four byte lanes that wrap together.
   localparam int RING_BYTES   = 1024;
   localparam int POS_W        = $clog2(RING_BYTES);
   localparam int BANKS        = 4;
   localparam int LANE_W       = 2;
   localparam int ROW_W        = POS_W - LANE_W;
   localparam int ROWS         = RING_BYTES / BANKS;
   localparam int PREFIX_BYTES = 4;
   localparam int LEN_W        = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [POS_W:0]   RING_EXT      = (POS_W + 1)'(RING_BYTES);
   localparam logic [POS_W-1:0] RING_LAST     = POS_W'(RING_BYTES - 1);
   localparam logic [31:0]      MAX_FRAME_LEN = 32'(RING_BYTES - 1 - PREFIX_BYTES);
   localparam logic [LEN_W-1:0] MAX_MSG_RESET = 16'd1019;

   typedef enum logic [1:0] {
      CMD_OPEN    = 2'd0,
      CMD_PUSH    = 2'd1,
      CMD_INSPECT = 2'd2,
      CMD_POP     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MSG   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTIFY_EN = 2'd1;

   // One write into the byte store: either the four prefix bytes starting at
   // pos, or a single byte (bytes[0]) at pos.
   typedef struct packed {
      logic                      en;
      logic                      prefix;
      logic [POS_W-1:0]          pos;
      logic [BANKS-1:0][7:0]     bytes;
   } wr_req_type;

   function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] pos,
                                                input logic [2:0] step);
      logic [POS_W:0] sum;
      sum = {1'b0, pos} + (POS_W + 1)'(step);
      if (sum >= RING_EXT) begin
         sum = sum - RING_EXT;
      end
      return sum[POS_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] ring_used(input logic [POS_W-1:0] wr_pos,
                                                  input logic [POS_W-1:0] rd_pos);
      logic [POS_W:0] diff;
      diff = {1'b0, wr_pos} - {1'b0, rd_pos};
      if (diff[POS_W]) begin
         diff = diff + RING_EXT;
      end
      return diff[POS_W-1:0];
   endfunction

endpackage

@@ rtl/length_prefixed_frame_ring.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_frame_ring: byte ring of length-prefixed frames
// A writer opens a frame and pushes its payload bytes; a reader inspects the
// head frame and pops its bytes. One command item, one result.
// ----------------------------------------------------------------------------
// The block takes one command item in every clock cycle (busy stays low) and
// answers each with exactly one result. The item is held in the input
// register and resolved there, and its result is registered in the result
// register; rsp_valid is high for a single cycle with each result.
// The receiver cannot stall the result, and it never has to: results come
// out in order at the same rate as items go in. The byte store is four
// byte-wide RAM lanes with a registered read: the four bytes at the read
// position are fetched at the edge that accepts an item, and the item is
// resolved in the following cycle from those bytes and the ring pointers.
// The ring holds RING_BYTES bytes, one of which is always kept free. The
// store has no reset and no clearing pass; only committed bytes are ever
// read. Configuration writes are always ready and should be made while no
// item is in flight.
// ----------------------------------------------------------------------------
module length_prefixed_frame_ring (
   input  logic                              clock,
   input  logic                              reset,
   // Command items
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_command,
   input  logic [lpfr_pkg::LEN_W-1:0]        req_frame_length,
   input  logic [7:0]                        req_data_byte,
   input  logic [lpfr_pkg::LEN_W-1:0]        req_buffer_space,
   // Results
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [lpfr_pkg::LEN_W-1:0]        rsp_frame_length_res,
   output logic [7:0]                        rsp_data_byte_res,
   output logic                              rsp_last_byte,
   output logic                              rsp_notify,
   output logic [lpfr_pkg::LEN_W-1:0]        rsp_bytes_used,
   output logic [lpfr_pkg::LEN_W-1:0]        rsp_bytes_free,
   // Register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lpfr_pkg::CSR_DATA_W-1:0]   csr_data
);
   import lpfr_pkg::*;

   // Input register.
   logic              in_valid_ff;
   cmd_type           cmd_ff;
   logic [LEN_W-1:0]  flen_ff;
   logic [7:0]        dbyte_ff;
   logic [LEN_W-1:0]  bspace_ff;

   // Configuration registers.
   logic [LEN_W-1:0]  max_msg_ff;
   logic              notify_en_ff;

   // Ring pointers and frame state.
   logic [POS_W-1:0]  cwp_ff,   cwp_in;    // committed write position
   logic [POS_W-1:0]  wc_ff,    wc_in;     // write cursor of the open frame
   logic [POS_W-1:0]  wrem_ff,  wrem_in;   // payload bytes still to push
   logic              wopen_ff, wopen_in;
   logic [POS_W-1:0]  fsp_ff,   fsp_in;    // start of the open frame
   logic              eao_ff,   eao_in;    // ring was empty when it opened
   logic [POS_W-1:0]  rp_ff,    rp_in;     // read position
   logic [POS_W-1:0]  rrem_ff,  rrem_in;   // payload bytes still to pop
   logic              ropen_ff, ropen_in;

   // Result register.
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_last_ff;
   logic              rsp_note_ff;
   logic [POS_W-1:0]  rsp_used_ff;
   logic [POS_W-1:0]  rsp_free_ff;

   // Per-item results.
   status_type        status;
   logic [LEN_W-1:0]  len_res;
   logic [7:0]        byte_res;
   logic              last;
   logic              note;
   logic              commit;

   logic [POS_W-1:0]  used_cur;
   logic [POS_W-1:0]  free_cur;
   logic [POS_W-1:0]  used_next;
   logic [LEN_W:0]    open_need;
   logic [31:0]       mlen;
   logic [BANKS-1:0][7:0] window;
   wr_req_type        wr;
   logic [POS_W-1:0]  store_rd_pos;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // -------------------------------------------------------------------------
   // Byte store. It always reads the four bytes at the read position that
   // the next item will see, so the window matches rp_ff in every cycle.
   // -------------------------------------------------------------------------
   assign store_rd_pos = reset ? '0 : rp_in;

   lpfr_store u_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd_pos (store_rd_pos),
      .window (window)
   );

   // The prefix is stored little-endian, so the window reads it directly.
   assign mlen      = {window[3], window[2], window[1], window[0]};
   assign used_cur  = ring_used(cwp_ff, rp_ff);
   assign free_cur  = RING_LAST - used_cur;
   assign open_need = {1'b0, flen_ff} + (LEN_W + 1)'(PREFIX_BYTES);

   // -------------------------------------------------------------------------
   // Command decode. Everything an item does is settled here, combinationally.
   // -------------------------------------------------------------------------
   always_comb begin
      cwp_in   = cwp_ff;
      wc_in    = wc_ff;
      wrem_in  = wrem_ff;
      wopen_in = wopen_ff;
      fsp_in   = fsp_ff;
      eao_in   = eao_ff;
      rp_in    = rp_ff;
      rrem_in  = rrem_ff;
      ropen_in = ropen_ff;
      status   = STATUS_OK;
      len_res  = '0;
      byte_res = '0;
      last     = 1'b0;
      note     = 1'b0;
      commit   = 1'b0;
      wr       = '0;

      if (in_valid_ff) begin
         unique case (cmd_ff)
            CMD_OPEN: begin
               // Opening while a frame is open restarts, if there is room, at the
               // committed write position, dropping the old frame.
               if (open_need > (LEN_W + 1)'(free_cur)) begin
                  status = STATUS_EMPTY;
               end else begin
                  eao_in       = (used_cur == '0);
                  fsp_in       = cwp_ff;
                  wr.en        = 1'b1;
                  wr.prefix    = 1'b1;
                  wr.pos       = cwp_ff;
                  wr.bytes[0]  = flen_ff[7:0];
                  wr.bytes[1]  = flen_ff[15:8];
                  wc_in        = pos_add(cwp_ff, 3'(PREFIX_BYTES));
                  wrem_in      = flen_ff[POS_W-1:0];
                  wopen_in     = 1'b1;
                  // A frame with no payload is committed right away.
                  commit       = (flen_ff == '0);
               end
            end
            CMD_PUSH: begin
               if (!wopen_ff) begin
                  status = STATUS_ERROR;
               end else begin
                  wr.en       = 1'b1;
                  wr.prefix   = 1'b0;
                  wr.pos      = wc_ff;
                  wr.bytes[0] = dbyte_ff;
                  wc_in       = pos_add(wc_ff, 3'd1);
                  wrem_in     = wrem_ff - 1'b1;
                  commit      = (wrem_in == '0);
               end
            end
            CMD_INSPECT: begin
               if (ropen_ff) begin
                  status = STATUS_ERROR;
               end else if (used_cur < POS_W'(PREFIX_BYTES)) begin
                  status = STATUS_EMPTY;
               end else if ((mlen == '0) || (mlen > {16'h0, max_msg_ff}) ||
                            (mlen > MAX_FRAME_LEN)) begin
                  status = STATUS_ERROR;
               end else if ((mlen + 32'(PREFIX_BYTES)) > 32'(used_cur)) begin
                  status = STATUS_EMPTY;
               end else if ({16'h0, bspace_ff} < mlen) begin
                  status = STATUS_ERROR;
               end else begin
                  rp_in    = pos_add(rp_ff, 3'(PREFIX_BYTES));
                  rrem_in  = mlen[POS_W-1:0];
                  ropen_in = 1'b1;
                  len_res  = mlen[LEN_W-1:0];
               end
            end
            CMD_POP: begin
               if (!ropen_ff) begin
                  status = STATUS_ERROR;
               end else begin
                  byte_res = window[0];
                  rp_in    = pos_add(rp_ff, 3'd1);
                  rrem_in  = rrem_ff - 1'b1;
                  if (rrem_in == '0) begin
                     last     = 1'b1;
                     ropen_in = 1'b0;
                  end
               end
            end
         endcase

         // Commit: the frame becomes visible to the reader. The reader is
         // told when it had nothing left to read before this frame, if notify_en_ff is set.
         if (commit) begin
            note     = (eao_in || (rp_ff == fsp_in)) && notify_en_ff;
            cwp_in   = wc_in;
            wopen_in = 1'b0;
            wrem_in  = '0;
         end
      end
   end

   assign used_next = ring_used(cwp_in, rp_in);

   // -------------------------------------------------------------------------
   // Registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         max_msg_ff   <= MAX_MSG_RESET;
         notify_en_ff <= 1'b1;
         cwp_ff       <= '0;
         wc_ff        <= '0;
         wrem_ff      <= '0;
         wopen_ff     <= 1'b0;
         fsp_ff       <= '0;
         eao_ff       <= 1'b0;
         rp_ff        <= '0;
         rrem_ff      <= '0;
         ropen_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start && !busy;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MAX_MSG) begin
               max_msg_ff <= csr_data;
            end else if (csr_index == CSR_NOTIFY_EN) begin
               notify_en_ff <= csr_data[0];
            end
         end
         cwp_ff       <= cwp_in;
         wc_ff        <= wc_in;
         wrem_ff      <= wrem_in;
         wopen_ff     <= wopen_in;
         fsp_ff       <= fsp_in;
         eao_ff       <= eao_in;
         rp_ff        <= rp_in;
         rrem_ff      <= rrem_in;
         ropen_ff     <= ropen_in;
         rsp_valid_ff <= in_valid_ff;
      end

      if (start && !busy) begin
         cmd_ff    <= cmd_type'(req_command);
         flen_ff   <= req_frame_length;
         dbyte_ff  <= req_data_byte;
         bspace_ff <= req_buffer_space;
      end

      if (in_valid_ff) begin
         rsp_status_ff <= status;
         rsp_len_ff    <= len_res;
         rsp_byte_ff   <= byte_res;
         rsp_last_ff   <= last;
         rsp_note_ff   <= note;
         rsp_used_ff   <= used_next;
         rsp_free_ff   <= RING_LAST - used_next;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_frame_length_res = rsp_len_ff;
   assign rsp_data_byte_res    = rsp_byte_ff;
   assign rsp_last_byte        = rsp_last_ff;
   assign rsp_notify           = rsp_note_ff;
   assign rsp_bytes_used       = LEN_W'(rsp_used_ff);
   assign rsp_bytes_free       = LEN_W'(rsp_free_ff);

   // -------------------------------------------------------------------------
   // Assertions.
   // -------------------------------------------------------------------------
   // An open write frame always has payload left to push.
   a_wopen_remaining: assert property (@(posedge clock) disable iff (reset)
      wopen_ff |-> (wrem_ff != '0))
      else $error("write frame open with nothing left to push");

   // An open read frame always has payload left to pop.
   a_ropen_remaining: assert property (@(posedge clock) disable iff (reset)
      ropen_ff |-> (rrem_ff != '0))
      else $error("read frame open with nothing left to pop");

   // Notify only comes with a successful commit.
   a_notify_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_notify) |-> (rsp_status == STATUS_OK))
      else $error("notify raised on a failed item");

   // The last byte of a frame closes the read frame.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte) |-> (!ropen_ff && (rsp_status == STATUS_OK)))
      else $error("read frame still open after its last byte");

   // Used and free bytes always add up to RING_LAST, one less than the ring size.
   a_used_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_used_ff + rsp_free_ff) == RING_LAST))
      else $error("used and free byte counts disagree");

endmodule

@@ rtl/lpfr_ram.sv @@
// ----------------------------------------------------------------------------
// lpfr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lpfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lpfr_store.sv @@
// ----------------------------------------------------------------------------
// lpfr_store: four-lane byte store of the frame ring
// Byte position p lives in lane p[1:0], row p>>2, so four consecutive bytes
// hit each lane once. Every cycle the four bytes from rd_pos on are read;
// a write to the same row in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module lpfr_store (
   input  logic                           clock,
   input  logic                           reset,
   input  lpfr_pkg::wr_req_type           wr,
   input  logic [lpfr_pkg::POS_W-1:0]     rd_pos,
   output logic [lpfr_pkg::BANKS-1:0][7:0] window
);
   import lpfr_pkg::*;

   logic [BANKS-1:0]     bank_we;
   logic [ROW_W-1:0]     bank_waddr [BANKS];
   logic [7:0]           bank_wdata [BANKS];
   logic [ROW_W-1:0]     bank_raddr [BANKS];
   logic [7:0]           bank_rdata [BANKS];
   logic [7:0]           bank_data  [BANKS];
   logic [LANE_W-1:0]    wr_off     [BANKS];
   logic [LANE_W-1:0]    rd_off     [BANKS];
   logic [POS_W-1:0]     wr_bpos    [BANKS];
   logic [POS_W-1:0]     rd_bpos    [BANKS];

   logic [BANKS-1:0]     fwd_hit_ff;
   logic [BANKS-1:0]     fwd_hit_in;
   logic [7:0]           fwd_data_ff [BANKS];
   logic [LANE_W-1:0]    rd_lane_ff;

   always_comb begin
      for (int b = 0; b < BANKS; b++) begin
         wr_off[b]     = LANE_W'(b) - wr.pos[LANE_W-1:0];
         wr_bpos[b]    = pos_add(wr.pos, {1'b0, wr_off[b]});
         bank_we[b]    = wr.en && (wr.prefix || (wr_off[b] == '0));
         bank_waddr[b] = wr_bpos[b][POS_W-1:LANE_W];
         bank_wdata[b] = wr.bytes[wr_off[b]];
         rd_off[b]     = LANE_W'(b) - rd_pos[LANE_W-1:0];
         rd_bpos[b]    = pos_add(rd_pos, {1'b0, rd_off[b]});
         bank_raddr[b] = rd_bpos[b][POS_W-1:LANE_W];
         fwd_hit_in[b] = bank_we[b] && (bank_waddr[b] == bank_raddr[b]);
         bank_data[b]  = fwd_hit_ff[b] ? fwd_data_ff[b] : bank_rdata[b];
      end
   end

   for (genvar g = 0; g < BANKS; g++) begin : g_lane
      lpfr_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we[g]),
         .wr_addr (bank_waddr[g]),
         .wr_data (bank_wdata[g]),
         .rd_addr (bank_raddr[g]),
         .rd_data (bank_rdata[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= '0;
         rd_lane_ff <= '0;
      end else begin
         fwd_hit_ff <= fwd_hit_in;
         rd_lane_ff <= rd_pos[LANE_W-1:0];
      end
      for (int b = 0; b < BANKS; b++) begin
         fwd_data_ff[b] <= bank_wdata[b];
      end
   end

   // Rotate lanes so that window[k] is the byte at the read position plus k.
   always_comb begin
      for (int k = 0; k < BANKS; k++) begin
         window[k] = bank_data[rd_lane_ff + LANE_W'(k)];
      end
   end

endmodule
